/* src/svn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svn_pkg: shared types and constants of the smoothed value-noise unit
// Field widths, hash multipliers and the records passed between stages.
// ----------------------------------------------------------------------------
package svn_pkg;

  localparam int COORD_W  = 31;
  localparam int SEED_W   = 32;
  localparam int SHIFT_W  = 5;
  localparam int VAL_W    = 16;
  localparam int HASH_W   = 31;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = 18;
  localparam int CORNERS  = 4;

  localparam logic [HASH_W-1:0] HASH_X   = 31'd374761393;
  localparam logic [HASH_W-1:0] HASH_Z   = 31'd668265263;
  localparam logic [HASH_W-1:0] HASH_S   = 31'd1103515245;
  localparam logic [HASH_W-1:0] HASH_MIX = 31'd1274126177;

  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef val_t [CORNERS-1:0]  corner_t;

  // Lattice cell and fraction of one request, with the low bits of the seed only.
  typedef struct packed {
    logic [HASH_W-1:0] gx;
    logic [HASH_W-1:0] gz;
    logic [FRAC_W-1:0] ux;
    logic [FRAC_W-1:0] uz;
    logic [HASH_W-1:0] seed;
  } cell_t;

endpackage
`default_nettype wire

/* src/svn_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svn_in_if: request channel of the value-noise unit
// Valid/ready handshake carrying one sample request.
// ----------------------------------------------------------------------------
interface svn_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [svn_pkg::COORD_W-1:0]  coord_x;
  logic signed [svn_pkg::COORD_W-1:0]  coord_z;
  logic signed [svn_pkg::SEED_W-1:0]   noise_seed;
  logic        [svn_pkg::SHIFT_W-1:0]  cell_shift;

  modport source (output valid, output coord_x, output coord_z, output noise_seed,
                  output cell_shift, input ready);
  modport sink   (input valid, input coord_x, input coord_z, input noise_seed,
                  input cell_shift, output ready);
endinterface
`default_nettype wire

/* src/svn_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svn_out_if: result channel of the value-noise unit
// Valid/ready handshake carrying one noise sample.
// ----------------------------------------------------------------------------
interface svn_out_if;
  logic                        valid;
  logic                        ready;
  logic [svn_pkg::VAL_W-1:0]   noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

/* src/smooth_value_noise_2d_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smooth_value_noise_2d_unit: smoothed 2-D value-noise sampler
// Hashes the four corners of a lattice cell and blends them with smoothstep.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on in_if (coord_x, coord_z, noise_seed, cell_shift) and a
//   16-bit sample leaves on out_if for each one, in request order.
//   The datapath is a nine-stage pipeline: one register for the cell stage,
//   four for the corner hash and smoothstep weights side by side, and four
//   for the bilinear blend. A request passes the cell register, then the hash
//   and weight stages, then the blend stages, before its sample is on out_if.
//   Throughput is one request per cycle while out_if does not stall, as
//   every stage takes a new item each cycle; the clock rate is set by the
//   longest stage, a single 31 by 31 bit multiply.
//   The whole pipeline advances together. When the output register holds a
//   sample that the receiver does not take, every stage freezes and in_if
//   ready is low, so nothing is lost or repeated; bubbles move on freely.
//   A synchronous reset clears the stage valid bits only; payload registers
//   are not reset.
// ----------------------------------------------------------------------------
module smooth_value_noise_2d_unit (
  input  logic         clk,
  input  logic         rst_n,
  svn_in_if.sink       in_if,
  svn_out_if.source    out_if
);

  localparam int PIPE_DEPTH = 9;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  svn_pkg::cell_t        lattice;
  svn_pkg::corner_t      corner;
  svn_pkg::weight_t      tx;
  svn_pkg::weight_t      tz;
  svn_pkg::val_t         noise;

  assign adv         = !vld_r[PIPE_DEPTH-1] || out_if.ready;
  assign in_if.ready = adv;
  assign vld_nxt     = {vld_r[PIPE_DEPTH-2:0], in_if.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  svn_cell u_cell (
    .clk        (clk),
    .en         (adv),
    .coord_x    (in_if.coord_x),
    .coord_z    (in_if.coord_z),
    .noise_seed (in_if.noise_seed),
    .cell_shift (in_if.cell_shift),
    .cell_r     (lattice)
  );

  svn_hash u_hash (
    .clk      (clk),
    .en       (adv),
    .lattice  (lattice),
    .corner_r (corner)
  );

  svn_weight u_weight (
    .clk     (clk),
    .en      (adv),
    .lattice (lattice),
    .tx_r    (tx),
    .tz_r    (tz)
  );

  svn_lerp u_lerp (
    .clk     (clk),
    .en      (adv),
    .corner  (corner),
    .tx      (tx),
    .tz      (tz),
    .noise_r (noise)
  );

  assign out_if.valid       = vld_r[PIPE_DEPTH-1];
  assign out_if.noise_value = noise;

  // A held sample must stop new transfers from entering.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("request taken while the output is stalled");

  // An item in the stage before the output register reaches the output when the pipe moves.
  a_last_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[PIPE_DEPTH-2]) |=> out_if.valid)
    else $error("sample lost between final stages");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

/* src/svn_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svn_cell: lattice cell and fraction stage
// Floors both coordinates by the cell size and scales the fractions to Q16.
// ----------------------------------------------------------------------------
module svn_cell (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [svn_pkg::COORD_W-1:0] coord_x,
  input  logic signed [svn_pkg::COORD_W-1:0] coord_z,
  input  logic signed [svn_pkg::SEED_W-1:0]  noise_seed,
  input  logic        [svn_pkg::SHIFT_W-1:0] cell_shift,
  output svn_pkg::cell_t                     cell_r
);

  logic signed [svn_pkg::COORD_W-1:0] gx;
  logic signed [svn_pkg::COORD_W-1:0] gz;
  logic        [svn_pkg::COORD_W-1:0] frac_mask;
  logic        [svn_pkg::COORD_W-1:0] fx;
  logic        [svn_pkg::COORD_W-1:0] fz;
  svn_pkg::cell_t                     cell_nxt;

  // An arithmetic shift floors towards minus infinity, so the remainder is
  // simply the low bits of the coordinate.
  assign gx        = coord_x >>> cell_shift;
  assign gz        = coord_z >>> cell_shift;
  assign frac_mask = ~({svn_pkg::COORD_W{1'b1}} << cell_shift);
  assign fx        = coord_x & frac_mask;
  assign fz        = coord_z & frac_mask;

  always_comb begin
    cell_nxt.gx   = gx;
    cell_nxt.gz   = gz;
    cell_nxt.ux   = svn_pkg::FRAC_W'({fx, {svn_pkg::FRAC_W{1'b0}}} >> cell_shift);
    cell_nxt.uz   = svn_pkg::FRAC_W'({fz, {svn_pkg::FRAC_W{1'b0}}} >> cell_shift);
    cell_nxt.seed = noise_seed[svn_pkg::HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/svn_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svn_hash: four-corner lattice hash pipeline
// Four stages: products, corner mix, final multiply, fold to 16 bits.
// ----------------------------------------------------------------------------
module svn_hash (
  input  logic             clk,
  input  logic             en,
  input  svn_pkg::cell_t   lattice,
  output svn_pkg::corner_t corner_r
);

  localparam int HW = svn_pkg::HASH_W;

  logic [2*HW-1:0] a_prod;
  logic [2*HW-1:0] b_prod;
  logic [2*HW-1:0] s_prod;
  logic [HW-1:0]   a_r;
  logic [HW-1:0]   b_r;
  logic [HW-1:0]   s_r;
  logic [HW-1:0]   a1;
  logic [HW-1:0]   b1;
  logic [svn_pkg::CORNERS-1:0][HW-1:0] n_mix;
  logic [svn_pkg::CORNERS-1:0][HW-1:0] pre_nxt;
  logic [svn_pkg::CORNERS-1:0][HW-1:0] pre_r;
  logic [svn_pkg::CORNERS-1:0][2*HW-1:0] m_prod;
  logic [svn_pkg::CORNERS-1:0][HW-1:0] mix_nxt;
  logic [svn_pkg::CORNERS-1:0][HW-1:0] mix_r;
  svn_pkg::corner_t corner_nxt;

  // Only the low 31 bits of each 62-bit product are kept.
  assign a_prod = lattice.gx * svn_pkg::HASH_X;
  assign b_prod = lattice.gz * svn_pkg::HASH_Z;
  assign s_prod = lattice.seed * svn_pkg::HASH_S;

  // The neighbour one cell on is the same product plus the multiplier.
  assign a1 = a_r + svn_pkg::HASH_X;
  assign b1 = b_r + svn_pkg::HASH_Z;

  always_comb begin
    n_mix[0] = a_r ^ b_r ^ s_r;
    n_mix[1] = a1  ^ b_r ^ s_r;
    n_mix[2] = a_r ^ b1  ^ s_r;
    n_mix[3] = a1  ^ b1  ^ s_r;
    for (int k = 0; k < svn_pkg::CORNERS; k++) begin
      pre_nxt[k]    = n_mix[k] ^ (n_mix[k] >> 13);
      m_prod[k]     = pre_r[k] * svn_pkg::HASH_MIX;
      mix_nxt[k]    = m_prod[k][HW-1:0];
      corner_nxt[k] = mix_r[k][svn_pkg::VAL_W-1:0] ^ {1'b0, mix_r[k][HW-1:svn_pkg::VAL_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_prod[HW-1:0];
      b_r      <= b_prod[HW-1:0];
      s_r      <= s_prod[HW-1:0];
      pre_r    <= pre_nxt;
      mix_r    <= mix_nxt;
      corner_r <= corner_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/svn_weight.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svn_weight: smoothstep weight pipeline for both axes
// Four stages computing 3u^2 - 2u^3 in Q16 with truncating divisions.
// ----------------------------------------------------------------------------
module svn_weight (
  input  logic             clk,
  input  logic             en,
  input  svn_pkg::cell_t   lattice,
  output svn_pkg::weight_t tx_r,
  output svn_pkg::weight_t tz_r
);

  localparam int FW = svn_pkg::FRAC_W;

  logic [1:0][FW-1:0]   u_in;
  logic [1:0][2*FW-1:0] sq_r;
  logic [1:0][FW-1:0]   u_d2_r;
  logic [1:0][FW-1:0]   u2_r;
  logic [1:0][FW-1:0]   u_d3_r;
  logic [1:0][2*FW-1:0] u3p_nxt;
  logic [1:0][2*FW-1:0] u3p_r;
  logic [1:0][FW-1:0]   u2_d4_r;
  logic [1:0][svn_pkg::WEIGHT_W-1:0] w_nxt;

  assign u_in = {lattice.uz, lattice.ux};

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      u3p_nxt[k] = u2_r[k] * u_d3_r[k];
      // u3 never exceeds u2, so the weight stays non-negative.
      w_nxt[k] = svn_pkg::WEIGHT_W'({u2_d4_r[k], 1'b0}) + svn_pkg::WEIGHT_W'(u2_d4_r[k])
               - svn_pkg::WEIGHT_W'({u3p_r[k][2*FW-1:FW], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        sq_r[k]    <= u_in[k] * u_in[k];
        u_d2_r[k]  <= u_in[k];
        u2_r[k]    <= sq_r[k][2*FW-1:FW];
        u_d3_r[k]  <= u_d2_r[k];
        u3p_r[k]   <= u3p_nxt[k];
        u2_d4_r[k] <= u2_r[k];
      end
      tx_r <= w_nxt[0];
      tz_r <= w_nxt[1];
    end
  end

endmodule
`default_nettype wire

/* src/svn_lerp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svn_lerp: bilinear blend pipeline
// Four stages: edge products, edge values, vertical product, final sum.
// ----------------------------------------------------------------------------
module svn_lerp (
  input  logic              clk,
  input  logic              en,
  input  svn_pkg::corner_t  corner,
  input  svn_pkg::weight_t  tx,
  input  svn_pkg::weight_t  tz,
  output svn_pkg::val_t     noise_r
);

  localparam int VW = svn_pkg::VAL_W;
  localparam int WW = svn_pkg::WEIGHT_W;
  localparam int PW = 40;
  localparam int QW = PW - 16;
  localparam int EW = 20;

  // Divide a product by 65536, truncating towards zero.
  function automatic logic signed [QW-1:0] q16_trunc(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] adj;
    adj = p + (p[PW-1] ? 40'sd65535 : 40'sd0);
    return adj[PW-1:16];
  endfunction

  logic signed [VW:0]      d_top;
  logic signed [VW:0]      d_bot;
  logic signed [VW+WW:0]   p_top_r;
  logic signed [VW+WW:0]   p_bot_r;
  svn_pkg::val_t           v00_r;
  svn_pkg::val_t           v01_r;
  svn_pkg::weight_t        tz_d6_r;
  logic signed [EW-1:0]    top_nxt;
  logic signed [EW-1:0]    bot_nxt;
  logic signed [EW-1:0]    top_r;
  logic signed [EW-1:0]    bot_r;
  svn_pkg::weight_t        tz_d7_r;
  logic signed [EW:0]      d_vert;
  logic signed [EW+WW+1:0] p_vert;
  logic signed [EW+WW+1:0] p_vert_r;
  logic signed [EW-1:0]    top_d8_r;
  logic signed [QW-1:0]    q_vert;

  assign d_top = signed'({1'b0, corner[1]}) - signed'({1'b0, corner[0]});
  assign d_bot = signed'({1'b0, corner[3]}) - signed'({1'b0, corner[2]});

  assign top_nxt = EW'(signed'({8'h00, v00_r}) + q16_trunc(PW'(p_top_r)));
  assign bot_nxt = EW'(signed'({8'h00, v01_r}) + q16_trunc(PW'(p_bot_r)));

  assign d_vert = (EW+1)'(bot_r) - (EW+1)'(top_r);
  assign p_vert = d_vert * signed'({1'b0, tz_d7_r});
  assign q_vert = q16_trunc(PW'(p_vert_r));

  always_ff @(posedge clk) begin
    if (en) begin
      p_top_r  <= d_top * signed'({1'b0, tx});
      p_bot_r  <= d_bot * signed'({1'b0, tx});
      v00_r    <= corner[0];
      v01_r    <= corner[2];
      tz_d6_r  <= tz;
      top_r    <= top_nxt;
      bot_r    <= bot_nxt;
      tz_d7_r  <= tz_d6_r;
      p_vert_r <= p_vert;
      top_d8_r <= top_r;
      // An overshooting weight wraps here, as only the low bits are kept.
      noise_r  <= top_d8_r[VW-1:0] + q_vert[VW-1:0];
    end
  end

endmodule
`default_nettype wire
